>>> design/oadm_pkg.sv
package oadm_pkg;

  // item and register field widths
  localparam int unsigned NUM_SENSORS = 5;
  localparam int unsigned STEER_W     = 16;
  localparam int unsigned RANGE_W     = 16;
  localparam int unsigned VELO_W      = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned REG_IDX_W   = ADDR_W - 2;

  // internal datapath widths
  localparam int unsigned WEIGHT_W     = 17;
  localparam int unsigned WEIGHT_STEPS = 17;
  localparam int unsigned DIFF_W       = 19;
  localparam int unsigned PA_W         = DIFF_W + CFG_W + 1;
  localparam int unsigned PC_W         = WEIGHT_W + CFG_W;
  localparam int unsigned ANG_W        = 18;
  localparam int unsigned AABS_W       = 17;
  localparam int unsigned PT_W         = AABS_W + CFG_W;
  localparam int unsigned VEL_W        = 21;
  localparam int unsigned MAG_W        = 20;
  localparam int unsigned DIV_STEPS    = 14;

  localparam int unsigned AVOID_SHIFT  = 18;
  localparam int unsigned TURN_SHIFT   = 14;
  localparam int unsigned CENTER_SHIFT = 16;

  // stage positions after the weight pipe
  localparam int unsigned DIV_SETUP   = 8;
  localparam int unsigned POST_STAGES = DIV_SETUP + DIV_STEPS + 2;

  localparam logic [MAG_W-1:0] ONE_Q14 = MAG_W'(16384);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TURN_DAMPING  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_DAMPING = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_HORIZON = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_AVOID_GAIN    = 3'd4;

  localparam logic [CFG_W-1:0] RST_MAX_SPEED     = 16'd4096;
  localparam logic [CFG_W-1:0] RST_TURN_DAMPING  = 16'd8192;
  localparam logic [CFG_W-1:0] RST_SPEED_DAMPING = 16'd8192;
  localparam logic [CFG_W-1:0] RST_RANGE_HORIZON = 16'd100;
  localparam logic [CFG_W-1:0] RST_AVOID_GAIN    = 16'd8192;

  // sensor lanes
  localparam int unsigned SENS_FAR_LEFT   = 0;
  localparam int unsigned SENS_NEAR_LEFT  = 1;
  localparam int unsigned SENS_CENTER     = 2;
  localparam int unsigned SENS_NEAR_RIGHT = 3;
  localparam int unsigned SENS_FAR_RIGHT  = 4;

  typedef logic [NUM_SENSORS-1:0][RANGE_W-1:0]  range_vec_t;
  typedef logic [NUM_SENSORS-1:0][WEIGHT_W-1:0] weight_vec_t;

  // one wheel in the normalization divider
  typedef struct packed {
    logic               neg;
    logic               sat;
    logic [MAG_W-1:0]   rem;
    logic [DIV_STEPS-1:0] quo;
    logic [VELO_W-1:0]  raw;
  } oadm_lane_t;

endpackage

>>> design/oadm_if.sv
interface oadm_cmd_if;
  import oadm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [STEER_W-1:0] steer_cmd;
  logic [RANGE_W-1:0]        range_far_left;
  logic [RANGE_W-1:0]        range_near_left;
  logic [RANGE_W-1:0]        range_center;
  logic [RANGE_W-1:0]        range_near_right;
  logic [RANGE_W-1:0]        range_far_right;

  modport source (
    output valid, steer_cmd, range_far_left, range_near_left, range_center,
           range_near_right, range_far_right,
    input  ready
  );

  modport sink (
    input  valid, steer_cmd, range_far_left, range_near_left, range_center,
           range_near_right, range_far_right,
    output ready
  );
endinterface

interface oadm_vel_if;
  import oadm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VELO_W-1:0] left_velocity;
  logic signed [VELO_W-1:0] right_velocity;

  modport source (
    output valid, left_velocity, right_velocity,
    input  ready
  );

  modport sink (
    input  valid, left_velocity, right_velocity,
    output ready
  );
endinterface

>>> design/oadm_weight_pipe.sv
module oadm_weight_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic signed [oadm_pkg::STEER_W-1:0] steer_i,
  input  oadm_pkg::range_vec_t          range_i,
  input  logic [oadm_pkg::CFG_W-1:0]    horizon_i,
  output logic                          vld_o,
  output logic signed [oadm_pkg::STEER_W-1:0] steer_o,
  output oadm_pkg::weight_vec_t         weight_o
);
  import oadm_pkg::*;

  // one quotient bit per stage, five lanes side by side
  logic [WEIGHT_STEPS-1:0][NUM_SENSORS-1:0][RANGE_W-1:0]  rem_q, rem_d;
  logic [WEIGHT_STEPS-1:0][NUM_SENSORS-1:0][WEIGHT_W-1:0] quo_q, quo_d;
  logic [WEIGHT_STEPS-1:0][STEER_W-1:0]                   steer_q;
  logic [WEIGHT_STEPS-1:0]                                vld_q;

  always_comb begin
    logic             near;
    logic [RANGE_W:0] dbl;
    for (int s = 0; s < NUM_SENSORS; s++) begin
      near = (range_i[s] < horizon_i);
      rem_d[0][s] = '0;
      // reading of zero is the only case with the top quotient bit set
      quo_d[0][s] = WEIGHT_W'(near && (range_i[s] == '0));
      if (near && (range_i[s] != '0)) begin
        rem_d[0][s] = horizon_i - range_i[s];
      end
    end
    for (int k = 1; k < WEIGHT_STEPS; k++) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        dbl = {rem_q[k-1][s], 1'b0};
        // a zero remainder never subtracts, which also covers a zero horizon
        if ((dbl >= {1'b0, horizon_i}) && (dbl != '0)) begin
          rem_d[k][s] = RANGE_W'(dbl - {1'b0, horizon_i});
          quo_d[k][s] = {quo_q[k-1][s][WEIGHT_W-2:0], 1'b1};
        end else begin
          rem_d[k][s] = dbl[RANGE_W-1:0];
          quo_d[k][s] = {quo_q[k-1][s][WEIGHT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[WEIGHT_STEPS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      steer_q <= {steer_q[WEIGHT_STEPS-2:0], steer_i};
    end
  end

  assign vld_o    = vld_q[WEIGHT_STEPS-1];
  assign steer_o  = steer_q[WEIGHT_STEPS-1];
  assign weight_o = quo_q[WEIGHT_STEPS-1];

endmodule

>>> design/obstacle_aware_diff_drive_mixer_unit.sv
// Obstacle-aware differential drive mixer. Each item on cmd_i carries a steering
// command and five range readings; one item of left and right wheel velocities
// (signed Q1.14, within [-1, 1]) leaves on vel_o for each. The block is a fixed
// pipeline that takes one item per cycle while the output skid is empty. It is made
// of the 17-stage restoring divider that turns readings into closeness weights, the
// multiply and add stages of the mixer, and the 14-stage divider that normalizes
// the wheel speeds. A one-entry output skid keeps the input open while a finished
// result waits; once it fills, the whole pipeline holds. Registers are written
// through the APB port at byte address 4*index and are meant to change only
// while the block is idle.
module obstacle_aware_diff_drive_mixer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  oadm_cmd_if.sink                      cmd_i,
  oadm_vel_if.source                    vel_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [oadm_pkg::ADDR_W-1:0]   paddr,
  input  logic [oadm_pkg::APB_DW-1:0]   pwdata,
  output logic [oadm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import oadm_pkg::*;

  localparam int unsigned SIDE_LEFT  = 0;
  localparam int unsigned SIDE_RIGHT = 1;

  // configuration registers
  logic [CFG_W-1:0] max_speed_q, turn_damping_q, speed_damping_q;
  logic [CFG_W-1:0] range_horizon_q, avoid_gain_q;

  logic en;
  logic skid_full_q, skid_full_d;

  // weight pipe
  range_vec_t                range_in;
  logic                      w_vld;
  logic signed [STEER_W-1:0] w_steer;
  weight_vec_t               w_weight;

  // post-weight stages
  logic [POST_STAGES-1:0]    vld_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic [WEIGHT_W-1:0]       wc_q;
  logic signed [STEER_W-1:0] steer1_q, steer2_q;
  logic signed [PA_W-1:0]    pa_q;
  logic [PC_W-1:0]           pc_q;
  logic signed [ANG_W-1:0]   ang3_q, ang4_q, ang5_q, ang6_q;
  logic [WEIGHT_W-1:0]       closs3_q, closs4_q, closs5_q;
  logic [AABS_W-1:0]         aabs_q;
  logic [PT_W-1:0]           pt_q;
  logic signed [VEL_W-1:0]   speed_q;
  logic signed [VEL_W-1:0]   left_q, right_q;
  logic [1:0][MAG_W-1:0]     mag_q;
  logic [1:0]                neg_q;
  logic [1:0][VELO_W-1:0]    raw_q;

  logic signed [PA_W-1:0]    pa_d;
  logic signed [ANG_W-1:0]   ang_d;
  logic [AABS_W-1:0]         aabs_d;
  logic signed [VEL_W-1:0]   speed_d, ang_ext;

  // normalization divider, index 0 is the setup stage
  oadm_lane_t [DIV_STEPS:0][1:0] lane_q, lane_d;
  logic [DIV_STEPS:0][MAG_W-1:0] div_q, div_d;
  logic [DIV_STEPS:0]            bypass_q, bypass_d;

  logic signed [VELO_W-1:0] f_left_q, f_right_q, skid_left_q, skid_right_q;
  logic [1:0][VELO_W-1:0]   f_val_d;
  logic                     f_vld;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q     <= RST_MAX_SPEED;
      turn_damping_q  <= RST_TURN_DAMPING;
      speed_damping_q <= RST_SPEED_DAMPING;
      range_horizon_q <= RST_RANGE_HORIZON;
      avoid_gain_q    <= RST_AVOID_GAIN;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[ADDR_W-1:2])
        REG_MAX_SPEED:     max_speed_q     <= pwdata[CFG_W-1:0];
        REG_TURN_DAMPING:  turn_damping_q  <= pwdata[CFG_W-1:0];
        REG_SPEED_DAMPING: speed_damping_q <= pwdata[CFG_W-1:0];
        REG_RANGE_HORIZON: range_horizon_q <= pwdata[CFG_W-1:0];
        REG_AVOID_GAIN:    avoid_gain_q    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_MAX_SPEED:     prdata = APB_DW'(max_speed_q);
      REG_TURN_DAMPING:  prdata = APB_DW'(turn_damping_q);
      REG_SPEED_DAMPING: prdata = APB_DW'(speed_damping_q);
      REG_RANGE_HORIZON: prdata = APB_DW'(range_horizon_q);
      REG_AVOID_GAIN:    prdata = APB_DW'(avoid_gain_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // the whole pipeline holds only while the skid entry is occupied
  assign en          = !skid_full_q;
  assign cmd_i.ready = en;

  always_comb begin
    range_in[SENS_FAR_LEFT]   = cmd_i.range_far_left;
    range_in[SENS_NEAR_LEFT]  = cmd_i.range_near_left;
    range_in[SENS_CENTER]     = cmd_i.range_center;
    range_in[SENS_NEAR_RIGHT] = cmd_i.range_near_right;
    range_in[SENS_FAR_RIGHT]  = cmd_i.range_far_right;
  end

  oadm_weight_pipe u_weight (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (cmd_i.valid),
    .steer_i   (cmd_i.steer_cmd),
    .range_i   (range_in),
    .horizon_i (range_horizon_q),
    .vld_o     (w_vld),
    .steer_o   (w_steer),
    .weight_o  (w_weight)
  );

  // ---------------------------------------------------------------- mixer math
  assign pa_d    = $signed(PA_W'(diff_q)) * $signed(PA_W'({1'b0, avoid_gain_q}));
  assign ang_d   = {{(ANG_W-STEER_W){steer2_q[STEER_W-1]}}, steer2_q}
                 + pa_q[PA_W-1:AVOID_SHIFT];
  assign aabs_d  = ang3_q[ANG_W-1] ? AABS_W'(-ang3_q) : AABS_W'(ang3_q);
  assign speed_d = VEL_W'(max_speed_q) - VEL_W'(pt_q[PT_W-1:TURN_SHIFT])
                 - VEL_W'(closs5_q);
  assign ang_ext = {{(VEL_W-ANG_W){ang6_q[ANG_W-1]}}, ang6_q};

  // ---------------------------------------------------------------- normalization
  always_comb begin
    logic             big_l, big_r;
    logic [MAG_W:0]   dbl;
    oadm_lane_t       prev;
    big_l = mag_q[SIDE_LEFT]  > ONE_Q14;
    big_r = mag_q[SIDE_RIGHT] > ONE_Q14;
    // left wheel takes precedence as the divisor
    div_d[0]    = big_l ? mag_q[SIDE_LEFT] : mag_q[SIDE_RIGHT];
    bypass_d[0] = !big_l && !big_r;
    for (int s = 0; s < 2; s++) begin
      lane_d[0][s].neg = neg_q[s];
      lane_d[0][s].sat = mag_q[s] >= div_d[0];
      lane_d[0][s].rem = (mag_q[s] >= div_d[0]) ? '0 : mag_q[s];
      lane_d[0][s].quo = '0;
      lane_d[0][s].raw = raw_q[s];
    end
    for (int k = 1; k <= DIV_STEPS; k++) begin
      div_d[k]    = div_q[k-1];
      bypass_d[k] = bypass_q[k-1];
      for (int s = 0; s < 2; s++) begin
        prev = lane_q[k-1][s];
        dbl  = {prev.rem, 1'b0};
        lane_d[k][s] = prev;
        if (dbl >= {1'b0, div_q[k-1]}) begin
          lane_d[k][s].rem = MAG_W'(dbl - {1'b0, div_q[k-1]});
          lane_d[k][s].quo = {prev.quo[DIV_STEPS-2:0], 1'b1};
        end else begin
          lane_d[k][s].rem = dbl[MAG_W-1:0];
          lane_d[k][s].quo = {prev.quo[DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    logic [VELO_W-1:0] fmag;
    oadm_lane_t        fin;
    for (int s = 0; s < 2; s++) begin
      fin  = lane_q[DIV_STEPS][s];
      // a wheel at or above the divisor lands on full scale after the clamp
      fmag = fin.sat ? VELO_W'(ONE_Q14) : VELO_W'(fin.quo);
      f_val_d[s] = fin.neg ? -fmag : fmag;
      if (bypass_q[DIV_STEPS]) begin
        f_val_d[s] = fin.raw;
      end
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[POST_STAGES-2:0], w_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q   <= DIFF_W'(w_weight[SENS_FAR_LEFT]) + DIFF_W'(w_weight[SENS_NEAR_LEFT])
                - DIFF_W'(w_weight[SENS_NEAR_RIGHT]) - DIFF_W'(w_weight[SENS_FAR_RIGHT]);
      wc_q     <= w_weight[SENS_CENTER];
      steer1_q <= w_steer;

      pa_q     <= pa_d;
      pc_q     <= PC_W'(wc_q) * PC_W'(speed_damping_q);
      steer2_q <= steer1_q;

      ang3_q   <= ang_d;
      closs3_q <= pc_q[PC_W-1:CENTER_SHIFT];

      aabs_q   <= aabs_d;
      ang4_q   <= ang3_q;
      closs4_q <= closs3_q;

      pt_q     <= PT_W'(aabs_q) * PT_W'(turn_damping_q);
      ang5_q   <= ang4_q;
      closs5_q <= closs4_q;

      speed_q  <= speed_d;
      ang6_q   <= ang5_q;

      left_q   <= speed_q - ang_ext;
      right_q  <= speed_q + ang_ext;

      neg_q[SIDE_LEFT]  <= left_q[VEL_W-1];
      neg_q[SIDE_RIGHT] <= right_q[VEL_W-1];
      mag_q[SIDE_LEFT]  <= left_q[VEL_W-1] ? MAG_W'(-left_q) : MAG_W'(left_q);
      mag_q[SIDE_RIGHT] <= right_q[VEL_W-1] ? MAG_W'(-right_q) : MAG_W'(right_q);
      raw_q[SIDE_LEFT]  <= left_q[VELO_W-1:0];
      raw_q[SIDE_RIGHT] <= right_q[VELO_W-1:0];

      lane_q   <= lane_d;
      div_q    <= div_d;
      bypass_q <= bypass_d;

      f_left_q  <= f_val_d[SIDE_LEFT];
      f_right_q <= f_val_d[SIDE_RIGHT];

      // skid follows the last stage until it has to hold an item
      skid_left_q  <= f_left_q;
      skid_right_q <= f_right_q;
    end
  end

  // ---------------------------------------------------------------- output skid
  assign f_vld = vld_q[POST_STAGES-1];

  always_comb begin
    if (skid_full_q) begin
      skid_full_d = !vel_o.ready;
    end else begin
      skid_full_d = f_vld && !vel_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else begin
      skid_full_q <= skid_full_d;
    end
  end

  assign vel_o.valid          = skid_full_q || f_vld;
  assign vel_o.left_velocity  = skid_full_q ? skid_left_q : f_left_q;
  assign vel_o.right_velocity = skid_full_q ? skid_right_q : f_right_q;

`ifndef NO_ASSERTIONS
  // weights never exceed one in Q1.16
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_vld |-> (w_weight[SENS_FAR_LEFT] <= 17'h10000) &&
              (w_weight[SENS_NEAR_LEFT] <= 17'h10000) &&
              (w_weight[SENS_CENTER] <= 17'h10000) &&
              (w_weight[SENS_NEAR_RIGHT] <= 17'h10000) &&
              (w_weight[SENS_FAR_RIGHT] <= 17'h10000))
    else $error("closeness weight above one");

  // the wheel chosen as divisor must come out at full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[DIV_SETUP] && !bypass_q[0]) |-> (lane_q[0][SIDE_LEFT].sat ||
                                             lane_q[0][SIDE_RIGHT].sat))
    else $error("normalization divisor not saturating its own wheel");

  // a stalled result moves into the skid and the pipeline holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!skid_full_q && f_vld && !vel_o.ready) |=>
      (skid_full_q && !cmd_i.ready && (skid_left_q == $past(f_left_q))))
    else $error("stalled result not captured by skid");

  // every delivered velocity is within [-1, 1]
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vel_o.valid |-> (vel_o.left_velocity <= 16'sd16384) &&
                    (vel_o.left_velocity >= -16'sd16384) &&
                    (vel_o.right_velocity <= 16'sd16384) &&
                    (vel_o.right_velocity >= -16'sd16384))
    else $error("wheel velocity out of range");
`endif

endmodule
